>>> src/rvam_pkg.sv
// shared types, constants and register codes of the radial vignette alpha mask
package rvam_pkg;

  localparam int COORD_W        = 10;
  localparam int SIZE_W         = 11;
  localparam int SET_BITS       = 16;
  localparam int CFG_W          = 16;
  localparam int MIN_FRAME_SIZE = 32;
  localparam int MAX_FRAME_DEF  = 1024;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [SIZE_W-1:0]   FRAME_SIZE_RST = SIZE_W'(256);
  localparam logic [SET_BITS-1:0] LEVEL_RST      = SET_BITS'(0);
  localparam logic [SET_BITS-1:0] STRENGTH_RST   = SET_BITS'(65535);
  localparam logic [SET_BITS-1:0] INNER_RST      = SET_BITS'(32768);

  typedef enum logic [1:0] {
    CFG_FRAME_SIZE = 2'd0,
    CFG_LEVEL      = 2'd1,
    CFG_STRENGTH   = 2'd2,
    CFG_INNER      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic       coord_valid;
  } pix_out_t;

endpackage

>>> src/rvam_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module rvam_div_pipe #(
  parameter int DW = 12,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DW+QW-1:0]  num,
  input  logic [DW-1:0]     den,
  input  logic [SW-1:0]     in_sd,
  output logic              out_vld,
  output logic [QW-1:0]     quo,
  output logic [SW-1:0]     out_sd
);

  logic          vld_r [QW];
  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [SW-1:0] sd_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic          vld_i;
    logic [DW-1:0] rem_i;
    logic [QW-1:0] low_i;
    logic [QW-1:0] q_i;
    logic [SW-1:0] sd_i;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign vld_i = in_vld;
      assign rem_i = num[DW+QW-1:QW];
      assign low_i = num[QW-1:0];
      assign q_i   = '0;
      assign sd_i  = in_sd;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign q_i   = q_r[k-1];
      assign sd_i  = sd_r[k-1];
    end

    assign trial   = {rem_i, low_i[QW-1]};
    assign diff    = trial - {1'b0, den};
    assign ge      = (trial >= {1'b0, den});
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= {low_i[QW-2:0], 1'b0};
        q_r[k]   <= {q_i[QW-2:0], ge};
        sd_r[k]  <= sd_i;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign quo     = q_r[QW-1];
  assign out_sd  = sd_r[QW-1];

endmodule

>>> src/rvam_sqrt_pipe.sv
// pipelined integer square root, one root bit per stage
module rvam_sqrt_pipe #(
  parameter int RW = 17,
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [2*RW-1:0]   rad,
  input  logic [SW-1:0]     in_sd,
  output logic              out_vld,
  output logic [RW-1:0]     root,
  output logic [SW-1:0]     out_sd
);

  localparam int VW = 2 * RW;
  localparam int MW = RW + 1;

  logic            vld_r  [RW];
  logic [MW-1:0]   rem_r  [RW];
  logic [VW-1:0]   v_r    [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SW-1:0]   sd_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic          vld_i;
    logic [MW-1:0] rem_i;
    logic [VW-1:0] v_i;
    logic [RW-1:0] root_i;
    logic [SW-1:0] sd_i;
    logic [MW+1:0] trial_rem;
    logic [MW+1:0] trial;
    logic [MW+1:0] diff;
    logic          ge;
    logic [MW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign v_i    = rad;
      assign root_i = '0;
      assign sd_i   = in_sd;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign v_i    = v_r[k-1];
      assign root_i = root_r[k-1];
      assign sd_i   = sd_r[k-1];
    end

    assign trial_rem = {rem_i, v_i[VW-1:VW-2]};
    assign trial     = {1'b0, root_i, 2'b01};
    assign diff      = trial_rem - trial;
    assign ge        = (trial_rem >= trial);
    assign rem_nxt   = ge ? diff[MW-1:0] : trial_rem[MW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
      if (en) begin
        rem_r[k]  <= rem_nxt;
        v_r[k]    <= {v_i[VW-3:0], 2'b00};
        root_r[k] <= {root_i[RW-2:0], ge};
        sd_r[k]   <= sd_i;
      end
    end
  end

  assign out_vld = vld_r[RW-1];
  assign root    = root_r[RW-1];
  assign out_sd  = sd_r[RW-1];

endmodule

>>> src/radial_vignette_alpha_mask_top.sv
// top level of the radial vignette alpha mask pipeline
// One pixel coordinate word goes in and one alpha word comes out, one word per clock
// when the output side does not stall. The pipe holds three bit-per-stage units in
// line: the centre-offset dividers (FRAC_BITS+1 stages), the square root
// (FRAC_BITS+1 stages) and the ramp divider (FRAC_BITS+8 stages), plus eleven single
// stages of frame check, subtraction, multiply and rounding. The whole pipe advances
// together; a stall at the output freezes every stage and the input stall follows it
// in the same cycle. Registers are written through the plain write port and must only
// be changed while the pipe is empty. Pixels outside the frame, or any pixel when the
// frame size lies outside its legal range, come out with alpha zero and coord_valid low.
module radial_vignette_alpha_mask_top #(
  parameter int MAX_FRAME_SIZE = rvam_pkg::MAX_FRAME_DEF,
  parameter int FRAC_BITS      = rvam_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rvam_pkg::pix_in_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rvam_pkg::pix_out_t        out_word,
  input  logic                      cfg_we,
  input  rvam_pkg::cfg_idx_t        cfg_idx,
  input  logic [rvam_pkg::CFG_W-1:0] cfg_wdata
);
  import rvam_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int SH_L   = (F >= SET_BITS) ? F - SET_BITS : 0;
  localparam int SH_R   = (F >= SET_BITS) ? 0 : SET_BITS - F;
  localparam longint ONE_I     = longint'(1) << F;
  localparam longint INNER_MAX = (98 * ONE_I + 50) / 100;
  localparam logic [F-1:0] INNER_MAX_V = F'(INNER_MAX);
  localparam logic [F:0]   ONE_V       = {1'b1, {F{1'b0}}};
  // offset divider: divisor is twice the frame size
  localparam int O_DW   = SIZE_W + 1;
  localparam int O_QW   = F + 1;
  // ramp divider: quotient may reach about 2^(F+7) before it is clamped
  localparam int T_DW   = F + 1;
  localparam int T_QW   = F + 8;
  localparam int T_NW   = T_DW + T_QW;
  localparam int OS_W   = SET_BITS + F + 2;
  localparam int A_W    = OS_W + 8;

  // configuration registers
  logic [SIZE_W-1:0]   frame_size_r;
  logic [SET_BITS-1:0] level_r;
  logic [SET_BITS-1:0] strength_r;
  logic [SET_BITS-1:0] inner_q16_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RST;
      level_r      <= LEVEL_RST;
      strength_r   <= STRENGTH_RST;
      inner_q16_r  <= INNER_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FRAME_SIZE: frame_size_r <= cfg_wdata[SIZE_W-1:0];
        CFG_LEVEL:      level_r      <= cfg_wdata[SET_BITS-1:0];
        CFG_STRENGTH:   strength_r   <= cfg_wdata[SET_BITS-1:0];
        CFG_INNER:      inner_q16_r  <= cfg_wdata[SET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // values derived from the registers, settled long before any word reaches them
  logic [F+SET_BITS-1:0] inner_ext;
  logic [F-1:0]          inner_c_r;
  logic [F:0]            den_r;
  logic [2*SET_BITS-1:0] opac_prod;
  logic [SET_BITS-1:0]   opacity_r;

  assign inner_ext = ({{F{1'b0}}, inner_q16_r} << SH_L) >> SH_R;
  assign opac_prod = level_r * strength_r + (2*SET_BITS)'(1 << (SET_BITS - 1));

  always_ff @(posedge clk) begin
    inner_c_r <= (inner_ext[F-1:0] > INNER_MAX_V) ? INNER_MAX_V : inner_ext[F-1:0];
    den_r     <= ONE_V - {1'b0, inner_c_r};
    opacity_r <= opac_prod[2*SET_BITS-1:SET_BITS];
  end

  // whole pipe moves together
  logic adv;
  logic out_vld_r;
  pix_out_t out_r;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = !adv;

  // entry stage: frame check and distance of the pixel centre from the middle
  logic              size_ok;
  logic              frm_ok;
  logic [SIZE_W-1:0] twice_x, twice_y;
  logic [SIZE_W-1:0] d_x, d_y;
  logic              vld0_r, ok0_r;
  logic [SIZE_W-1:0] dx_r, dy_r;

  assign size_ok = (frame_size_r >= SIZE_W'(MIN_FRAME_SIZE)) &&
                   (32'(frame_size_r) <= 32'(MAX_FRAME_SIZE));
  assign frm_ok  = size_ok && ({1'b0, in_word.pixel_x} < frame_size_r) &&
                   ({1'b0, in_word.pixel_y} < frame_size_r);
  assign twice_x = {in_word.pixel_x, 1'b1};
  assign twice_y = {in_word.pixel_y, 1'b1};
  assign d_x     = (twice_x > frame_size_r) ? twice_x - frame_size_r : frame_size_r - twice_x;
  assign d_y     = (twice_y > frame_size_r) ? twice_y - frame_size_r : frame_size_r - twice_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_valid;
    end
    if (adv) begin
      ok0_r <= frm_ok;
      dx_r  <= d_x;
      dy_r  <= d_y;
    end
  end

  // centre offset: (d*2^(F+1) + size) / (2*size); the add is a concatenation
  logic [O_DW+O_QW-1:0] num_x, num_y;
  logic [O_DW-1:0]      den_o;
  logic                 vld_dx, vld_dy, ok_dx, ok_dy;
  logic [O_QW-1:0]      q_x, q_y;

  assign den_o = {frame_size_r, 1'b0};
  assign num_x = {1'b0, dx_r, (F+1)'(frame_size_r)};
  assign num_y = {1'b0, dy_r, (F+1)'(frame_size_r)};

  rvam_div_pipe #(.DW(O_DW), .QW(O_QW), .SW(1)) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vld0_r), .num(num_x), .den(den_o),
    .in_sd(ok0_r), .out_vld(vld_dx), .quo(q_x), .out_sd(ok_dx)
  );

  rvam_div_pipe #(.DW(O_DW), .QW(O_QW), .SW(1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vld0_r), .num(num_y), .den(den_o),
    .in_sd(ok0_r), .out_vld(vld_dy), .quo(q_y), .out_sd(ok_dy)
  );

  // squares, then their sum
  logic           vlda_r, oka_r, vldb_r, okb_r;
  logic [2*F-1:0] sqx_r, sqy_r;
  logic [2*F:0]   v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlda_r <= 1'b0;
      vldb_r <= 1'b0;
    end else if (adv) begin
      vlda_r <= vld_dx;
      vldb_r <= vlda_r;
    end
    if (adv) begin
      oka_r <= ok_dx & ok_dy;
      sqx_r <= q_x[F-1:0] * q_x[F-1:0];
      sqy_r <= q_y[F-1:0] * q_y[F-1:0];
      okb_r <= oka_r;
      v_r   <= {1'b0, sqx_r} + {1'b0, sqy_r};
    end
  end

  // radius
  logic       vld_s, ok_s;
  logic [F:0] r_s;

  rvam_sqrt_pipe #(.RW(F + 1), .SW(1)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vldb_r), .rad({1'b0, v_r}),
    .in_sd(okb_r), .out_vld(vld_s), .root(r_s), .out_sd(ok_s)
  );

  // distance past the clear inner radius
  logic       vldc_r, okc_r, gtc_r;
  logic [F:0] diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldc_r <= 1'b0;
    end else if (adv) begin
      vldc_r <= vld_s;
    end
    if (adv) begin
      okc_r  <= ok_s;
      gtc_r  <= r_s > {1'b0, inner_c_r};
      diff_r <= r_s - {1'b0, inner_c_r};
    end
  end

  // ramp position, rounded: the half-divisor add is again a concatenation
  logic [T_NW-1:0] num_t;
  logic            vld_t, ok_t, gt_t;
  logic [T_QW-1:0] q_t;

  assign num_t = {{(T_NW - 2*F - 1){1'b0}}, diff_r, den_r[F:1]};

  rvam_div_pipe #(.DW(T_DW), .QW(T_QW), .SW(2)) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(vldc_r), .num(num_t), .den(den_r),
    .in_sd({gtc_r, okc_r}), .out_vld(vld_t), .quo(q_t), .out_sd({gt_t, ok_t})
  );

  // smoothstep and final scaling
  logic             vldd_r, vlde_r, vldf_r, vldg_r, vldh_r, vldi_r;
  logic             okd_r, oke_r, okf_r, okg_r, okh_r, oki_r;
  logic [F:0]       t_r, te_r, t2_r;
  logic [2*F+1:0]   tt_r;
  logic [F+1:0]     w_r, s_r;
  logic [2*F+2:0]   p_r;
  logic [OS_W-1:0]  os_r;
  logic [2*F+1:0]   t2_sum;
  logic [2*F+3:0]   s_sum;
  logic [A_W-1:0]   a_sum;
  logic [A_W-1:0]   a_shift;
  logic [7:0]       alpha_nxt;

  assign t2_sum  = tt_r + (2*F+2)'(ONE_I >> 1);
  assign s_sum   = {1'b0, p_r} + (2*F+4)'(ONE_I >> 1);
  assign a_sum   = {os_r, 8'b0} - {8'b0, os_r} + A_W'(longint'(1) << (SET_BITS + F - 1));
  assign a_shift = a_sum >> (SET_BITS + F);
  assign alpha_nxt = !oki_r ? 8'd0 : ((a_shift > A_W'(255)) ? 8'd255 : a_shift[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldd_r    <= 1'b0;
      vlde_r    <= 1'b0;
      vldf_r    <= 1'b0;
      vldg_r    <= 1'b0;
      vldh_r    <= 1'b0;
      vldi_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vldd_r    <= vld_t;
      vlde_r    <= vldd_r;
      vldf_r    <= vlde_r;
      vldg_r    <= vldf_r;
      vldh_r    <= vldg_r;
      vldi_r    <= vldh_r;
      out_vld_r <= vldi_r;
    end
    if (adv) begin
      okd_r <= ok_t;
      t_r   <= !gt_t ? '0 : ((q_t > T_QW'(ONE_I)) ? ONE_V : q_t[F:0]);
      oke_r <= okd_r;
      tt_r  <= t_r * t_r;
      te_r  <= t_r;
      okf_r <= oke_r;
      t2_r  <= t2_sum[2*F:F];
      w_r   <= (F+2)'(3 * ONE_I) - {te_r, 1'b0};
      okg_r <= okf_r;
      p_r   <= t2_r * w_r;
      okh_r <= okg_r;
      s_r   <= s_sum[2*F+1:F];
      oki_r <= okh_r;
      os_r  <= opacity_r * s_r;
      out_r.alpha       <= alpha_nxt;
      out_r.coord_valid <= oki_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

  // checks
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word after reset");

  a_xy_lock: assert property (@(posedge clk) disable iff (!rst_n) vld_dx == vld_dy)
    else $error("offset dividers out of step");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_word.coord_valid |-> out_word.alpha == 8'd0)
    else $error("alpha set outside frame");

  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && $past(level_r == '0, 3) && level_r == '0 |-> out_word.alpha == 8'd0)
    else $error("alpha set with zero level");

endmodule

>>> bench/tb_radial_vignette_alpha_mask_top.sv
// testbench of the radial vignette alpha mask: random and directed pixels checked by a scoreboard
module tb_radial_vignette_alpha_mask_top;
  import rvam_pkg::*;

  localparam int LATENCY   = 3 * FRAC_BITS_DEF + 21;
  localparam int WDOG_LIMIT = 20000;

  // expected alpha words and the register copy that predicts them
  class alpha_scoreboard;
    logic [SIZE_W-1:0]   frame_size;
    logic [SET_BITS-1:0] level;
    logic [SET_BITS-1:0] strength;
    logic [SET_BITS-1:0] inner_set;
    pix_out_t            pending[$];
    int                  errors;

    function new();
      frame_size = FRAME_SIZE_RST;
      level      = LEVEL_RST;
      strength   = STRENGTH_RST;
      inner_set  = INNER_RST;
      errors     = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_FRAME_SIZE: frame_size = val[SIZE_W-1:0];
        CFG_LEVEL:      level      = val;
        CFG_STRENGTH:   strength   = val;
        CFG_INNER:      inner_set  = val;
        default: ;
      endcase
    endfunction

    function longint unsigned offset(longint unsigned idx, longint unsigned sz);
      longint unsigned tw, d;
      tw = 2 * idx + 1;
      d  = (tw > sz) ? tw - sz : sz - tw;
      return ((d << (FRAC_BITS_DEF + 1)) + sz) / (2 * sz);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v  -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function pix_out_t predict_alpha(pix_in_t w);
      longint unsigned one, nx, ny, r, inr, inr_max, t, t2, s, opac, a, den, sz;
      pix_out_t o;
      one = 64'd1 << FRAC_BITS_DEF;
      sz  = frame_size;
      o   = '0;
      if (sz < MIN_FRAME_SIZE || sz > MAX_FRAME_DEF || w.pixel_x >= sz || w.pixel_y >= sz)
        return o;
      nx = offset(w.pixel_x, sz);
      ny = offset(w.pixel_y, sz);
      r  = root(nx * nx + ny * ny);
      inr     = inner_set;
      inr_max = (98 * one + 50) / 100;
      if (inr > inr_max) inr = inr_max;
      if (r <= inr) begin
        t = 0;
      end else begin
        den = one - inr;
        t   = (((r - inr) << FRAC_BITS_DEF) + (den >> 1)) / den;
        if (t > one) t = one;
      end
      t2   = (t * t + (one >> 1)) >> FRAC_BITS_DEF;
      s    = (t2 * (3 * one - 2 * t) + (one >> 1)) >> FRAC_BITS_DEF;
      opac = (longint'(level) * strength + (64'd1 << (SET_BITS - 1))) >> SET_BITS;
      a    = (opac * s * 255 + (64'd1 << (SET_BITS + FRAC_BITS_DEF - 1)))
             >> (SET_BITS + FRAC_BITS_DEF);
      if (a > 255) a = 255;
      o.alpha       = a[7:0];
      o.coord_valid = 1'b1;
      return o;
    endfunction

    function void note_pixel(pix_in_t w);
      pending.push_back(predict_alpha(w));
    endfunction

    function void check_alpha(pix_out_t got);
      pix_out_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word alpha=%0d valid=%0b", $time, got.alpha, got.coord_valid);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.alpha !== exp_w.alpha) begin
        $display("%0t: alpha expected %0d actual %0d", $time, exp_w.alpha, got.alpha);
        errors++;
      end
      if (got.coord_valid !== exp_w.coord_valid) begin
        $display("%0t: coord_valid expected %0b actual %0b", $time,
                 exp_w.coord_valid, got.coord_valid);
        errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pix_in_t  in_word = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pix_out_t out_word;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_FRAME_SIZE;
  logic [CFG_W-1:0] cfg_wdata = '0;

  alpha_scoreboard sb = new();
  bit   hold_off = 1'b0;    // asks the receiver for one long stall
  bit   stall_rand = 1'b0;  // receiver stalls at random when set
  int   idle_cycles = 0;

  radial_vignette_alpha_mask_top u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word, .cfg_we, .cfg_idx, .cfg_wdata
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_alpha(out_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog: nothing moving for too long
  always @(posedge clk) begin
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAIL radial_vignette_alpha_mask_top");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : receiver
    int k;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (k = 0; k < 3 * LATENCY; k++) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_rand) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one pixel word and hold it until taken
  task automatic send_pixel(int x, int y);
    in_word  <= '{pixel_x: COORD_W'(x), pixel_y: COORD_W'(y)};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_pixel('{pixel_x: COORD_W'(x), pixel_y: COORD_W'(y)});
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // wait for the pipe to drain, so that a register can then be written
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic random_burst(int n);
    int sz, left;
    int x, y;
    sz   = int'(sb.frame_size);
    left = n;
    while (left > 0) begin
      repeat ($urandom_range(1, 12)) begin
        if (left > 0) begin
          // mostly inside the frame, some anywhere in the coordinate range
          if ($urandom_range(0, 7) == 0) begin
            x = int'($urandom_range(0, 1023));
            y = int'($urandom_range(0, 1023));
          end else if (sz >= 1 && sz <= 1024) begin
            x = int'($urandom_range(0, sz - 1));
            y = int'($urandom_range(0, sz - 1));
          end else begin
            x = int'($urandom_range(0, 1023));
            y = int'($urandom_range(0, 1023));
          end
          send_pixel(x, y);
          left--;
        end
      end
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
  endtask

  initial begin : stimulus
    int ph;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings, then full opacity
    send_pixel(0, 0);
    send_pixel(128, 128);
    send_pixel(255, 255);
    send_pixel(256, 0);
    send_pixel(0, 1023);
    drain();
    write_reg(CFG_LEVEL, 16'hFFFF);
    write_reg(CFG_STRENGTH, 16'hFFFF);
    send_pixel(0, 0);
    send_pixel(255, 0);
    send_pixel(127, 128);
    send_pixel(1023, 1023);
    drain();
    // inner radius above the clamp and at zero
    write_reg(CFG_INNER, 16'hFFFF);
    send_pixel(0, 0);
    send_pixel(0, 128);
    drain();
    write_reg(CFG_INNER, 16'h0000);
    send_pixel(0, 0);
    send_pixel(128, 128);
    drain();
    // frame size extremes and out-of-range sizes
    write_reg(CFG_FRAME_SIZE, 16'd32);
    send_pixel(0, 0);
    send_pixel(31, 31);
    send_pixel(32, 5);
    drain();
    write_reg(CFG_FRAME_SIZE, 16'd1024);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(511, 512);
    drain();
    write_reg(CFG_FRAME_SIZE, 16'd31);
    send_pixel(0, 0);
    drain();
    write_reg(CFG_FRAME_SIZE, 16'h07FF);
    send_pixel(5, 5);
    drain();

    // random phases over varied settings
    stall_rand = 1'b1;
    for (ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FRAME_SIZE, (ph == 0) ? 16'd1024 : (ph == 1) ? 16'd32 :
                (ph == 7) ? 16'($urandom) : 16'($urandom_range(32, 1024)));
      write_reg(CFG_LEVEL, (ph == 2) ? 16'h0000 : 16'($urandom));
      write_reg(CFG_STRENGTH, (ph == 3) ? 16'hFFFF : 16'($urandom));
      write_reg(CFG_INNER, (ph == 4) ? 16'hFFFF : 16'($urandom));
      if (ph == 5) hold_off = 1'b1;  // long receiver hold-off while words keep coming
      stall_rand = (ph != 6);
      // enough words in the hold-off phase to fill the whole pipe
      random_burst((ph == 5) ? 150 : 50);
      drain();
    end

    repeat (LATENCY + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS radial_vignette_alpha_mask_top");
    end else begin
      $display("FAIL radial_vignette_alpha_mask_top");
    end
    $finish;
  end

endmodule

>>> radial_vignette_alpha_mask_top.f
src/rvam_pkg.sv
src/rvam_div_pipe.sv
src/rvam_sqrt_pipe.sv
src/radial_vignette_alpha_mask_top.sv
bench/tb_radial_vignette_alpha_mask_top.sv
